[rtl/spq_pkg.sv]
// shared types and constants for the stable priority queue
`default_nettype none

package spq_pkg;

    localparam int PRIO_BITS   = 8;
    localparam int ID_BITS     = 16;
    localparam int STATUS_BITS = 2;
    localparam int OCC_BITS    = 5;

    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_POP  = 1'b1;

    localparam logic [STATUS_BITS-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_BITS-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STATUS_BITS-1:0] STATUS_FULL  = 2'd2;

    typedef struct packed {
        logic                 command;
        logic [PRIO_BITS-1:0] priority_req;
        logic [ID_BITS-1:0]   item_id;
    } spq_in_t;

    typedef struct packed {
        logic [STATUS_BITS-1:0] status;
        logic [ID_BITS-1:0]     popped_id;
        logic [OCC_BITS-1:0]    occupancy;
    } spq_out_t;

    // contents of one sorted slot
    typedef struct packed {
        logic                 valid;
        logic [PRIO_BITS-1:0] prio;
        logic [ID_BITS-1:0]   id;
    } spq_slot_t;

    // operation broadcast to every cell
    typedef struct packed {
        logic                 push;
        logic                 pop;
        logic [PRIO_BITS-1:0] prio;
        logic [ID_BITS-1:0]   id;
    } spq_ctrl_t;

endpackage

`default_nettype wire

[rtl/spq_cell.sv]
// one slot of the sorted shift-register queue
`default_nettype none

module spq_cell (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire spq_pkg::spq_ctrl_t ctrl,
    input  wire spq_pkg::spq_slot_t left_slot,
    input  wire logic              left_keep,
    input  wire spq_pkg::spq_slot_t right_slot,
    output spq_pkg::spq_slot_t     slot,
    output logic                   keep
);
    import spq_pkg::*;

    spq_slot_t slot_reg;
    spq_slot_t slot_next;

    // held entry stays ahead of a new one of equal or lower priority
    assign keep = slot_reg.valid && (slot_reg.prio >= ctrl.prio);
    assign slot = slot_reg;

    always_comb begin
        slot_next = slot_reg;
        if (ctrl.push) begin
            if (!keep) begin
                if (left_keep) begin
                    slot_next.valid = 1'b1;
                    slot_next.prio  = ctrl.prio;
                    slot_next.id    = ctrl.id;
                end else begin
                    slot_next = left_slot;
                end
            end
        end else if (ctrl.pop) begin
            slot_next = right_slot;
        end
    end

    always_ff @(posedge aclk) begin
        slot_reg.prio <= slot_next.prio;
        slot_reg.id   <= slot_next.id;
        if (!aresetn) begin
            slot_reg.valid <= 1'b0;
        end else begin
            slot_reg.valid <= slot_next.valid;
        end
    end

endmodule

`default_nettype wire

[rtl/stable_priority_queue.sv]
// top level: bounded stable priority queue built from a chain of sorted cells
//
//   port group     direction  contents
//   s_valid/ready  in         spq_in_t: command, priority_req, item_id
//   m_valid/ready  out        spq_out_t: status, popped_id, occupancy
//
// one transaction per cycle when not stalled: every cell updates in the cycle
// it is accepted, the result reaching the output register on the next cycle
// s_ready is high while the output register is empty or being drained,
// so a stalled m_ready stops input after one waiting result
// synchronous active-low reset empties the queue and the output register
`default_nettype none

module stable_priority_queue #(
    parameter int DEPTH = 16
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire spq_pkg::spq_in_t s_data,
    output logic               m_valid,
    input  wire logic          m_ready,
    output spq_pkg::spq_out_t  m_data
);
    import spq_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);

    spq_slot_t            slots [DEPTH];
    logic                 keeps [DEPTH];
    spq_ctrl_t            ctrl;
    logic                 accept;
    logic                 full;
    logic                 empty;
    logic [CW-1:0]        count_reg;
    logic [CW-1:0]        count_next;
    logic [CW+OCC_BITS-1:0] occ_ext;
    logic                 m_valid_reg;
    spq_out_t             m_data_reg;
    spq_out_t             m_data_next;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign full    = slots[DEPTH-1].valid;
    assign empty   = !slots[0].valid;

    assign ctrl.push = accept && (s_data.command == CMD_PUSH) && !full;
    assign ctrl.pop  = accept && (s_data.command == CMD_POP) && !empty;
    assign ctrl.prio = s_data.priority_req;
    assign ctrl.id   = s_data.item_id;

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            spq_slot_t left_slot;
            spq_slot_t right_slot;
            logic      left_keep;
            if (gi == 0) begin : g_head
                // head cell takes a new entry whenever it does not keep its own
                assign left_slot = '0;
                assign left_keep = 1'b1;
            end else begin : g_body
                assign left_slot = slots[gi-1];
                assign left_keep = keeps[gi-1];
            end
            if (gi == DEPTH - 1) begin : g_tail
                assign right_slot = '0;
            end else begin : g_mid
                assign right_slot = slots[gi+1];
            end
            spq_cell u_cell (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .ctrl      (ctrl),
                .left_slot (left_slot),
                .left_keep (left_keep),
                .right_slot(right_slot),
                .slot      (slots[gi]),
                .keep      (keeps[gi])
            );
        end
    endgenerate

    always_comb begin
        count_next = count_reg;
        if (ctrl.push) begin
            count_next = count_reg + 1'b1;
        end else if (ctrl.pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    assign occ_ext = {{OCC_BITS{1'b0}}, count_next};

    always_comb begin
        m_data_next.status    = STATUS_OK;
        m_data_next.popped_id = '0;
        m_data_next.occupancy = occ_ext[OCC_BITS-1:0];
        if (s_data.command == CMD_PUSH) begin
            if (full) begin
                m_data_next.status = STATUS_FULL;
            end
        end else begin
            if (empty) begin
                m_data_next.status = STATUS_EMPTY;
            end else begin
                m_data_next.popped_id = slots[0].id;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_data_reg <= m_data_next;
        end
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg <= count_next;
            if (accept) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire

[rtl/spq_checker.sv]
// port-level assertions for the stable priority queue and their bind
`default_nettype none

module spq_checker #(
    parameter int DEPTH = 16
) (
    input wire logic         aclk,
    input wire logic         aresetn,
    input wire logic         s_valid,
    input wire logic         s_ready,
    input wire spq_pkg::spq_in_t  s_data,
    input wire logic         m_valid,
    input wire logic         m_ready,
    input wire spq_pkg::spq_out_t m_data
);
    import spq_pkg::*;

    localparam int FULL_COUNT = DEPTH % (2 ** OCC_BITS);

    // a waiting input transaction keeps its payload until taken
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_data))
        else $error("input transaction changed or dropped while stalled");

    // a waiting result is held until taken
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed or dropped while stalled");

    a_no_result_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    a_empty_report: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.status == STATUS_EMPTY) |->
            (m_data.popped_id == '0) && (m_data.occupancy == '0))
        else $error("empty report with entries or a handle");

    a_full_report: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.status == STATUS_FULL) |->
            (m_data.popped_id == '0) && (m_data.occupancy == FULL_COUNT[OCC_BITS-1:0]))
        else $error("full report with wrong occupancy");

endmodule

bind stable_priority_queue spq_checker #(.DEPTH(DEPTH)) u_spq_checker (
    .aclk   (aclk),
    .aresetn(aresetn),
    .s_valid(s_valid),
    .s_ready(s_ready),
    .s_data (s_data),
    .m_valid(m_valid),
    .m_ready(m_ready),
    .m_data (m_data)
);

`default_nettype wire
